// File: src/sta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor threshold alarm bank package
// Shared widths, register indexes and limit codes for the alarm bank.
// ----------------------------------------------------------------------------
package sta_pkg;

  // Width of one signed sensor reading and of each limit register.
  localparam int READING_WIDTH = 32;

  // Hysteresis band register width (unsigned).
  localparam int HYST_W = 31;

  // Number of limits and the width of a limit identifier.
  localparam int NUM_LIMITS = 4;
  localparam int LIMIT_ID_W = 2;

  // Configuration write data must hold the widest register.
  localparam int CFG_DATA_W = (READING_WIDTH > HYST_W) ? READING_WIDTH : HYST_W;
  localparam int CFG_IDX_W  = 3;

  // Compare width: a limit plus or minus the band never overflows here.
  localparam int CMP_W = CFG_DATA_W + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARN_HIGH  = 3'd0,
    REG_WARN_LOW   = 3'd1,
    REG_CRIT_HIGH  = 3'd2,
    REG_CRIT_LOW   = 3'd3,
    REG_HYSTERESIS = 3'd4,
    REG_ENABLE     = 3'd5
  } cfg_reg_e;

  // Limit identifiers, same order as the enable mask and alarm bits.
  typedef enum logic [LIMIT_ID_W-1:0] {
    LIM_WARN_HIGH = 2'd0,
    LIM_WARN_LOW  = 2'd1,
    LIM_CRIT_HIGH = 2'd2,
    LIM_CRIT_LOW  = 2'd3
  } limit_e;

endpackage

// File: src/sta_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor threshold alarm bank channels
// Valid/ready channels for readings, alarm results and configuration writes.
// ----------------------------------------------------------------------------

// Reading channel: one signed sample per transaction.
interface sta_reading_if import sta_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [READING_WIDTH-1:0] reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

// Result channel: one alarm event or no-change report per transaction.
interface sta_result_if import sta_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic                            has_change;
  logic [LIMIT_ID_W-1:0]           limit_id;
  logic                            now_asserted;
  logic signed [READING_WIDTH-1:0] event_reading;
  logic                            critical_clear;
  logic [NUM_LIMITS-1:0]           alarm_bits;
  logic                            last;

  modport source (output valid, output has_change, output limit_id,
                  output now_asserted, output event_reading,
                  output critical_clear, output alarm_bits, output last,
                  input ready);
  modport sink   (input valid, input has_change, input limit_id,
                  input now_asserted, input event_reading,
                  input critical_clear, input alarm_bits, input last,
                  output ready);
endinterface

// Configuration channel: register index and write data.
interface sta_cfg_if import sta_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/sensor_threshold_alarm_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor threshold alarm bank
// Checks each reading against four limits with hysteresis and reports every
// alarm bit change, or a single no-change result, per reading.
// ----------------------------------------------------------------------------
//
//  Port     | Dir | Carries
//  ---------+-----+---------------------------------------------------------
//  cfg_i    | in  | register index and write data, one register per write
//  in_i     | in  | one signed reading per transaction
//  out_o    | out | one result per transaction, last marks a reading's end
//
//  A reading waits in the input register, where the limit compares run, and
//  then moves to the result register, which issues one result per cycle
//  while ready: 1 to 4 results per reading, one per changed bit (one if none).
//  The alarm state updates as a reading moves into the result register.
//  A stalled output holds the result register; an empty input register still
//  takes a new reading while the result register is busy. Reset clears all
//  alarms and configuration registers; configuration writes are always taken.
//
module sensor_threshold_alarm_bank
  import sta_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  sta_cfg_if.sink      cfg_i,
  sta_reading_if.sink  in_i,
  sta_result_if.source out_o
);

  // Configuration registers.
  logic [READING_WIDTH-1:0] limit_q [NUM_LIMITS];
  logic [HYST_W-1:0]        hyst_q;
  logic [NUM_LIMITS-1:0]    enable_q;

  // Alarm state and pipeline control.
  logic [NUM_LIMITS-1:0] alarm_q, alarm_d;
  logic                  s1_valid_q;
  logic                  s2_valid_q;

  // Input register payload.
  logic signed [READING_WIDTH-1:0] s1_reading_q;

  // Result register payload.
  logic signed [READING_WIDTH-1:0] s2_reading_q;
  logic [NUM_LIMITS-1:0]           s2_pending_q, s2_pending_d;
  logic [NUM_LIMITS-1:0]           s2_alarm_q;
  logic                            s2_crit_clear_q;

  // Compare results.
  logic signed [CMP_W-1:0] reading_ext;
  logic signed [CMP_W-1:0] hyst_ext;
  logic signed [CMP_W-1:0] lim_ext [NUM_LIMITS];
  logic [NUM_LIMITS-1:0]   set_hit;
  logic [NUM_LIMITS-1:0]   clr_hit;
  logic                    crit_hit;

  // Handshake helpers.
  logic                  out_last;
  logic                  out_fire;
  logic                  s2_free;
  logic                  s1_adv;
  logic                  in_fire;
  logic [LIMIT_ID_W-1:0] cur_id;

  // Configuration writes are taken in any cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LIMITS; i++) begin
        limit_q[i] <= '0;
      end
      hyst_q   <= '0;
      enable_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WARN_HIGH:  limit_q[LIM_WARN_HIGH] <= cfg_i.data[READING_WIDTH-1:0];
        REG_WARN_LOW:   limit_q[LIM_WARN_LOW]  <= cfg_i.data[READING_WIDTH-1:0];
        REG_CRIT_HIGH:  limit_q[LIM_CRIT_HIGH] <= cfg_i.data[READING_WIDTH-1:0];
        REG_CRIT_LOW:   limit_q[LIM_CRIT_LOW]  <= cfg_i.data[READING_WIDTH-1:0];
        REG_HYSTERESIS: hyst_q   <= cfg_i.data[HYST_W-1:0];
        REG_ENABLE:     enable_q <= cfg_i.data[NUM_LIMITS-1:0];
        default: ;
      endcase
    end
  end

  // Limit compares on the registered reading; each limit is independent.
  always_comb begin
    reading_ext = {{(CMP_W-READING_WIDTH){s1_reading_q[READING_WIDTH-1]}}, s1_reading_q};
    hyst_ext    = {{(CMP_W-HYST_W){1'b0}}, hyst_q};
    for (int i = 0; i < NUM_LIMITS; i++) begin
      lim_ext[i] = {{(CMP_W-READING_WIDTH){limit_q[i][READING_WIDTH-1]}}, limit_q[i]};
    end
    for (int i = 0; i < NUM_LIMITS; i++) begin
      if (i == LIM_WARN_HIGH || i == LIM_CRIT_HIGH) begin
        set_hit[i] = reading_ext >= lim_ext[i];
        clr_hit[i] = reading_ext < (lim_ext[i] - hyst_ext);
      end else begin
        set_hit[i] = reading_ext <= lim_ext[i];
        clr_hit[i] = reading_ext > (lim_ext[i] + hyst_ext);
      end
    end
    crit_hit = (enable_q[LIM_CRIT_HIGH] & set_hit[LIM_CRIT_HIGH])
             | (enable_q[LIM_CRIT_LOW]  & set_hit[LIM_CRIT_LOW]);
  end

  // Schmitt trigger update of each enabled alarm bit.
  always_comb begin
    for (int i = 0; i < NUM_LIMITS; i++) begin
      priority if (enable_q[i] && set_hit[i]) begin
        alarm_d[i] = 1'b1;
      end else if (enable_q[i] && clr_hit[i]) begin
        alarm_d[i] = 1'b0;
      end else begin
        alarm_d[i] = alarm_q[i];
      end
    end
  end

  // Lowest pending change is reported first.
  always_comb begin
    priority if (s2_pending_q[LIM_WARN_HIGH]) begin
      cur_id = LIM_WARN_HIGH;
    end else if (s2_pending_q[LIM_WARN_LOW]) begin
      cur_id = LIM_WARN_LOW;
    end else if (s2_pending_q[LIM_CRIT_HIGH]) begin
      cur_id = LIM_CRIT_HIGH;
    end else if (s2_pending_q[LIM_CRIT_LOW]) begin
      cur_id = LIM_CRIT_LOW;
    end else begin
      cur_id = LIM_WARN_HIGH;
    end
  end

  // Handshake and stage advance.
  assign out_last     = (s2_pending_q & (s2_pending_q - 1'b1)) == '0;
  assign out_fire     = s2_valid_q && out_o.ready;
  assign s2_free      = !s2_valid_q || (out_fire && out_last);
  assign s1_adv       = s1_valid_q && s2_free;
  assign in_i.ready   = !s1_valid_q || s1_adv;
  assign in_fire      = in_i.valid && in_i.ready;
  assign s2_pending_d = s2_pending_q & (s2_pending_q - 1'b1);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      alarm_q    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
        alarm_q    <= alarm_d;
      end else if (s2_free) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_reading_q <= in_i.reading;
    end
    if (s1_adv) begin
      s2_reading_q    <= s1_reading_q;
      s2_pending_q    <= alarm_q ^ alarm_d;
      s2_alarm_q      <= alarm_d;
      s2_crit_clear_q <= !crit_hit;
    end else if (out_fire) begin
      s2_pending_q <= s2_pending_d;
    end
  end

  // Result transaction.
  assign out_o.valid          = s2_valid_q;
  assign out_o.has_change     = |s2_pending_q;
  assign out_o.limit_id       = cur_id;
  assign out_o.now_asserted   = (|s2_pending_q) & s2_alarm_q[cur_id];
  assign out_o.event_reading  = s2_reading_q;
  assign out_o.critical_clear = s2_crit_clear_q;
  assign out_o.alarm_bits     = s2_alarm_q;
  assign out_o.last           = out_last;

endmodule

// File: dv/sta_alarm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm bank result checker
// Watches the configuration, reading and result channels of the alarm bank,
// predicts the alarm events of every accepted reading and compares each
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module sta_alarm_checker
  import sta_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  sta_cfg_if      cfg_bus,
  sta_reading_if  rd_bus,
  sta_result_if   res_bus,
  input  logic    drained_i,
  output int      fail_count_o
);

  // One result transaction as the block should issue it.
  typedef struct packed {
    logic                            has_change;
    logic [LIMIT_ID_W-1:0]           limit_id;
    logic                            now_asserted;
    logic signed [READING_WIDTH-1:0] event_reading;
    logic                            critical_clear;
    logic [NUM_LIMITS-1:0]           alarm_bits;
    logic                            last;
  } alarm_result_t;

  // Local copy of the register file and of the alarm bits.
  logic signed [READING_WIDTH-1:0] lim_q [NUM_LIMITS];
  logic [HYST_W-1:0]               band_q;
  logic [NUM_LIMITS-1:0]           enable_q;
  logic [NUM_LIMITS-1:0]           alarms_q;

  alarm_result_t awaited_alarms[$];
  int            mismatches = 0;
  logic          drain_checked = 1'b0;

  assign fail_count_o = mismatches;

  function automatic string describe(input alarm_result_t r);
    return $sformatf("chg=%0b lim=%0d on=%0b rdg=%h crit_clr=%0b bits=%b last=%0b",
                     r.has_change, r.limit_id, r.now_asserted, r.event_reading,
                     r.critical_clear, r.alarm_bits, r.last);
  endfunction

  // Only the first few failures are printed; the rest are counted.
  function automatic void note_failure(input string msg);
    if (mismatches < 10) begin
      $display("alarm check: %s", msg);
    end
    mismatches++;
  endfunction

  // Register write; bits above a register's width are dropped.
  function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_WARN_HIGH:  lim_q[LIM_WARN_HIGH] = value[READING_WIDTH-1:0];
      REG_WARN_LOW:   lim_q[LIM_WARN_LOW]  = value[READING_WIDTH-1:0];
      REG_CRIT_HIGH:  lim_q[LIM_CRIT_HIGH] = value[READING_WIDTH-1:0];
      REG_CRIT_LOW:   lim_q[LIM_CRIT_LOW]  = value[READING_WIDTH-1:0];
      REG_HYSTERESIS: band_q   = value[HYST_W-1:0];
      REG_ENABLE:     enable_q = value[NUM_LIMITS-1:0];
      default: ;
    endcase
  endfunction

  // Schmitt trigger per enabled limit, then one event per changed bit in
  // limit order, or a single no-change result.
  function automatic void predict_alarms(input logic signed [READING_WIDTH-1:0] sample);
    longint                value;
    longint                band;
    longint                lim;
    logic [NUM_LIMITS-1:0] prev;
    logic [NUM_LIMITS-1:0] nxt;
    logic                  upper;
    logic                  trip;
    logic                  drop;
    logic                  crit_hit;
    int                    changes;
    int                    emitted;
    alarm_result_t         item;
    value    = longint'(sample);
    band     = longint'({1'b0, band_q});
    prev     = alarms_q;
    nxt      = alarms_q;
    crit_hit = 1'b0;
    for (int i = 0; i < NUM_LIMITS; i++) begin
      if (enable_q[i]) begin
        lim   = longint'(lim_q[i]);
        upper = (i == LIM_WARN_HIGH) || (i == LIM_CRIT_HIGH);
        trip  = upper ? (value >= lim) : (value <= lim);
        drop  = upper ? (value < lim - band) : (value > lim + band);
        if (trip) begin
          nxt[i] = 1'b1;
          if ((i == LIM_CRIT_HIGH) || (i == LIM_CRIT_LOW)) begin
            crit_hit = 1'b1;
          end
        end else if (drop) begin
          nxt[i] = 1'b0;
        end
      end
    end
    alarms_q = nxt;

    item.event_reading  = sample;
    item.critical_clear = !crit_hit;
    item.alarm_bits     = nxt;
    changes = $countones(prev ^ nxt);
    emitted = 0;
    for (int i = 0; i < NUM_LIMITS; i++) begin
      if (prev[i] != nxt[i]) begin
        emitted++;
        item.has_change   = 1'b1;
        item.limit_id     = i[LIMIT_ID_W-1:0];
        item.now_asserted = nxt[i];
        item.last         = (emitted == changes);
        awaited_alarms.push_back(item);
      end
    end
    if (changes == 0) begin
      item.has_change   = 1'b0;
      item.limit_id     = '0;
      item.now_asserted = 1'b0;
      item.last         = 1'b1;
      awaited_alarms.push_back(item);
    end
  endfunction

  // Compare one accepted result against the oldest prediction.
  function automatic void check_result();
    alarm_result_t got;
    alarm_result_t want;
    got.has_change     = res_bus.has_change;
    got.limit_id       = res_bus.limit_id;
    got.now_asserted   = res_bus.now_asserted;
    got.event_reading  = res_bus.event_reading;
    got.critical_clear = res_bus.critical_clear;
    got.alarm_bits     = res_bus.alarm_bits;
    got.last           = res_bus.last;
    if (awaited_alarms.size() == 0) begin
      note_failure($sformatf("unexpected result: %s", describe(got)));
    end else begin
      want = awaited_alarms.pop_front();
      if (got !== want) begin
        note_failure($sformatf("mismatch: expected %s, got %s", describe(want),
                               describe(got)));
      end
    end
  endfunction

  // All channel activity of one clock edge is handled in a single process.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LIMITS; i++) begin
        lim_q[i] = '0;
      end
      band_q   = '0;
      enable_q = '0;
      alarms_q = '0;
      awaited_alarms.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        store_register(cfg_bus.index, cfg_bus.data);
      end
      if (rd_bus.valid && rd_bus.ready) begin
        predict_alarms(rd_bus.reading);
      end
      if (res_bus.valid && res_bus.ready) begin
        check_result();
      end
      if (drained_i && !drain_checked) begin
        drain_checked = 1'b1;
        if (awaited_alarms.size() != 0) begin
          note_failure($sformatf("%0d expected results never arrived",
                                 awaited_alarms.size()));
          mismatches += awaited_alarms.size() - 1;
        end
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm bank testbench
// Drives configuration phases and readings into the alarm bank with random
// gaps and output stalls, including one long output hold-off, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import sta_pkg::*;

  localparam int LIMIT_CYCLES   = 200000;
  localparam int HOLD_CYCLES    = 48;
  localparam int PHASE_READINGS = 30;
  localparam int Q              = 65536;

  localparam logic signed [READING_WIDTH-1:0] READING_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [READING_WIDTH-1:0] READING_MIN = 32'sh8000_0000;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  logic clk_i   = 1'b0;
  logic rst_ni;
  logic drained;
  logic calm;
  int   fail_count;
  int   taken     = 0;
  int   finished  = 0;
  int   cycles    = 0;
  int   hold_left = 0;
  logic hold_used = 1'b0;

  // Limits in force, used to aim readings at the switching points.
  logic signed [READING_WIDTH-1:0] aim_lim [NUM_LIMITS] = '{default: '0};
  logic [HYST_W-1:0]               aim_band = '0;

  sta_cfg_if     cfg ();
  sta_reading_if rd ();
  sta_result_if  res ();

  sensor_threshold_alarm_bank i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (rd),
    .out_o  (res)
  );

  sta_alarm_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_bus      (cfg),
    .rd_bus       (rd),
    .res_bus      (res),
    .drained_i    (drained),
    .fail_count_o (fail_count)
  );

  always #4 clk_i = ~clk_i;

  // A window of the run in which neither side idles.
  assign calm = (taken >= 100) && (taken < 140);

  // Count accepted readings and completed result bursts.
  always @(posedge clk_i) begin
    if (rd.valid && rd.ready) begin
      taken <= taken + 1;
    end
    if (res.valid && res.ready && res.last) begin
      finished <= finished + 1;
    end
  end

  // Output stalls, with one long hold-off that backs the block up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_used && (taken >= 60)) begin
      res.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      res.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one reading, with random idle cycles ahead of it.
  task automatic send_reading(input logic signed [READING_WIDTH-1:0] value);
    while (!calm && ($urandom_range(99) < 35)) begin
      rd.valid <= 1'b0;
      @(posedge clk_i);
    end
    rd.valid   <= 1'b1;
    rd.reading <= value;
    @(posedge clk_i);
    while (!rd.ready) begin
      @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every reading has finished its results.
  task automatic wait_idle();
    rd.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (finished != taken);
  endtask

  // One register write transaction; valid drops again afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) begin
      @(posedge clk_i);
    end
    cfg.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_WARN_HIGH:  aim_lim[LIM_WARN_HIGH] = value[READING_WIDTH-1:0];
      REG_WARN_LOW:   aim_lim[LIM_WARN_LOW]  = value[READING_WIDTH-1:0];
      REG_CRIT_HIGH:  aim_lim[LIM_CRIT_HIGH] = value[READING_WIDTH-1:0];
      REG_CRIT_LOW:   aim_lim[LIM_CRIT_LOW]  = value[READING_WIDTH-1:0];
      REG_HYSTERESIS: aim_band = value[HYST_W-1:0];
      default: ;
    endcase
  endtask

  // Program the whole register file once the block has drained.
  task automatic setup_limits(input logic [CFG_DATA_W-1:0] warn_hi,
                              input logic [CFG_DATA_W-1:0] warn_lo,
                              input logic [CFG_DATA_W-1:0] crit_hi,
                              input logic [CFG_DATA_W-1:0] crit_lo,
                              input logic [CFG_DATA_W-1:0] band,
                              input logic [CFG_DATA_W-1:0] mask);
    wait_idle();
    write_reg(REG_WARN_HIGH, warn_hi);
    write_reg(REG_WARN_LOW, warn_lo);
    write_reg(REG_CRIT_HIGH, crit_hi);
    write_reg(REG_CRIT_LOW, crit_lo);
    write_reg(REG_HYSTERESIS, band);
    write_reg(REG_ENABLE, mask);
  endtask

  function automatic logic signed [READING_WIDTH-1:0] extreme_value();
    case ($urandom_range(2))
      0:       return READING_MAX;
      1:       return READING_MIN;
      default: return '0;
    endcase
  endfunction

  // Mostly readings near a limit or its clearing point, some anywhere.
  function automatic logic signed [READING_WIDTH-1:0] pick_reading();
    int unsigned roll;
    longint      spot;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return $urandom;
    end
    if (roll < 14) begin
      return roll[0] ? READING_MAX : READING_MIN;
    end
    spot = longint'(aim_lim[$urandom_range(NUM_LIMITS - 1)]);
    if (roll < 60) begin
      spot += $urandom_range(1) ? longint'(aim_band) : -longint'(aim_band);
    end
    spot += longint'($urandom_range(32)) - 16;
    if (roll >= 90) begin
      spot += longint'($urandom_range(131072)) - 65536;
    end
    if (spot > longint'(READING_MAX)) begin
      spot = longint'(READING_MAX);
    end else if (spot < longint'(READING_MIN)) begin
      spot = longint'(READING_MIN);
    end
    return spot[READING_WIDTH-1:0];
  endfunction

  // Random register settings: ordered limits, arbitrary ones, or extremes.
  task automatic random_setup(input int style);
    int                    center;
    int                    gap;
    logic [CFG_DATA_W-1:0] lims [NUM_LIMITS];
    logic [CFG_DATA_W-1:0] band;
    center = $signed($urandom) >>> 2;
    gap    = $urandom_range(1 << 22, 1);
    case (style)
      0: begin
        lims[LIM_WARN_HIGH] = center + gap;
        lims[LIM_WARN_LOW]  = center - gap;
        lims[LIM_CRIT_HIGH] = center + 2 * gap;
        lims[LIM_CRIT_LOW]  = center - 2 * gap;
        band     = $urandom_range(gap);
        band[31] = $urandom_range(1);
      end
      1: begin
        for (int i = 0; i < NUM_LIMITS; i++) begin
          lims[i] = $urandom;
        end
        band = $urandom;
      end
      default: begin
        for (int i = 0; i < NUM_LIMITS; i++) begin
          lims[i] = extreme_value();
        end
        band = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
    endcase
    setup_limits(lims[LIM_WARN_HIGH], lims[LIM_WARN_LOW], lims[LIM_CRIT_HIGH],
                 lims[LIM_CRIT_LOW], band, $urandom);
    if ($urandom_range(1)) begin
      write_reg($urandom_range(1) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
    end
  endtask

  // Main stimulus.
  initial begin
    rst_ni      = 1'b0;
    drained     = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = REG_WARN_HIGH;
    cfg.data    = '0;
    rd.valid    = 1'b0;
    rd.reading  = '0;
    res.ready   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All limits disabled after reset.
    send_reading('0);
    send_reading(READING_MAX);

    // Ordinary limits with a band of two units.
    setup_limits(80 * Q, 10 * Q, 90 * Q, 5 * Q, 2 * Q, 32'h0000_000F);
    send_reading(50 * Q);   // nothing changes
    send_reading(80 * Q);   // warning high asserts at the limit
    send_reading(79 * Q);   // inside the band, holds
    send_reading(77 * Q);   // below limit minus band, clears
    send_reading(95 * Q);   // both high limits assert
    send_reading(4 * Q);    // all four bits flip in one reading
    send_reading(11 * Q);   // critical low clears, warning low holds
    send_reading(13 * Q);   // warning low clears
    send_reading(95 * Q);

    // Disabled limits keep their bits; upper mask bits are dropped.
    wait_idle();
    write_reg(REG_ENABLE, 32'hFFFF_FFF0);
    send_reading(-100 * Q);
    wait_idle();
    write_reg(REG_ENABLE, 32'h0000_0003);
    send_reading('0);

    // Limits at the range ends and the widest band.
    setup_limits(READING_MAX, READING_MIN, READING_MAX, READING_MIN,
                 32'hFFFF_FFFF, 32'hFFFF_FFF5);
    send_reading(READING_MAX);
    send_reading('0);
    send_reading(READING_MIN);
    wait_idle();
    write_reg(REG_ENABLE, 32'h0000_000A);
    send_reading(READING_MIN);
    wait_idle();
    write_reg(REG_HYSTERESIS, 32'h0);
    write_reg(IDX_SPARE_A, 32'hFFFF_FFFF);
    write_reg(IDX_SPARE_B, 32'hFFFF_FFFF);
    send_reading(READING_MIN + 1);
    send_reading(-1);

    // Random phases.
    for (int phase = 0; phase < 6; phase++) begin
      random_setup((phase == 2) ? 1 : (phase == 4) ? 2 : 0);
      for (int n = 0; n < PHASE_READINGS; n++) begin
        send_reading(pick_reading());
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    drained <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
